// File: src/tlbf_pkg.sv
// ----------------------------------------------------------------------------
// tlbf_pkg
// Shared widths, codes and transfer types of the FIFO-replacement
// translation buffer.
// ----------------------------------------------------------------------------
package tlbf_pkg;

  localparam int TLB_DEPTH = 16;
  localparam int PID_W     = 16;
  localparam int PAGE_W    = 20;
  localparam int FRAME_W   = 20;
  localparam int POS_W     = 4;
  localparam int CFG_W     = 5;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_INSERT = 1'b1
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [PID_W-1:0]   process_id;
    logic [PAGE_W-1:0]  page_number;
    logic [FRAME_W-1:0] frame_in;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic [FRAME_W-1:0] frame_out;
    logic [POS_W-1:0]   hit_position;
    logic               evicted;
  } res_t;

endpackage

// File: src/tlbf_store.sv
// ----------------------------------------------------------------------------
// tlbf_store
// Entry registers, fill count and oldest-slot pointer. Compares a request
// against every entry in parallel and applies an insert on the same edge.
// ----------------------------------------------------------------------------
module tlbf_store #(
  parameter int DEPTH = tlbf_pkg::TLB_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     req_valid,
  input  tlbf_pkg::req_t           req,
  input  logic                     cfg_we,
  input  logic [tlbf_pkg::CFG_W-1:0] cfg_value,
  output tlbf_pkg::res_t           res
);
  import tlbf_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  logic [PID_W-1:0]   ent_pid_r   [DEPTH];
  logic [PAGE_W-1:0]  ent_page_r  [DEPTH];
  logic [FRAME_W-1:0] ent_frame_r [DEPTH];
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic [IDX_W-1:0]   oldest_r, oldest_nxt;
  logic [CNT_W-1:0]   cap_r, cap_nxt;

  logic [SUM_W-1:0]   age [DEPTH];
  logic [DEPTH-1:0]   match;
  logic [DEPTH-1:0]   match_up;
  logic [IDX_W-1:0]   sel_up, sel_any, sel;
  logic [SUM_W-1:0]   ins_sum;
  logic [IDX_W-1:0]   ins_slot;
  logic               full;
  logic               do_insert;

  function automatic logic [CNT_W-1:0] clamp_cap(input logic [CFG_W-1:0] v);
    logic [CNT_W-1:0] c;
    if (v == '0) begin
      c = CNT_W'(1);
    end else if (int'(v) > DEPTH) begin
      c = CNT_W'(DEPTH);
    end else begin
      c = CNT_W'(v);
    end
    return c;
  endfunction

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      if (IDX_W'(i) >= oldest_r) begin
        age[i] = SUM_W'(i) - SUM_W'(oldest_r);
      end else begin
        age[i] = SUM_W'(i) + SUM_W'(cap_r) - SUM_W'(oldest_r);
      end
      match[i] = (CNT_W'(i) < cap_r) && (age[i] < SUM_W'(fill_r)) &&
                 (ent_pid_r[i] == req.process_id) &&
                 (ent_page_r[i] == req.page_number);
      match_up[i] = match[i] && (IDX_W'(i) >= oldest_r);
    end
  end

  always_comb begin
    sel_up  = '0;
    sel_any = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match_up[i]) begin
        sel_up = IDX_W'(i);
      end
      if (match[i]) begin
        sel_any = IDX_W'(i);
      end
    end
    sel = (|match_up) ? sel_up : sel_any;
  end

  always_comb begin
    full     = (fill_r >= cap_r);
    ins_sum  = SUM_W'(oldest_r) + SUM_W'(fill_r);
    ins_slot = (ins_sum >= SUM_W'(cap_r)) ? IDX_W'(ins_sum - SUM_W'(cap_r))
                                          : IDX_W'(ins_sum);
    if (full) begin
      ins_slot = oldest_r;
    end
    do_insert = req_valid && (req.op == OP_INSERT);
  end

  always_comb begin
    res = '0;
    unique case (req.op)
      OP_LOOKUP: begin
        if (|match) begin
          res.hit          = 1'b1;
          res.frame_out    = ent_frame_r[sel];
          res.hit_position = POS_W'(age[sel]);
        end
      end
      OP_INSERT: begin
        res.evicted = full;
      end
      default: res = '0;
    endcase
  end

  always_comb begin
    fill_nxt   = fill_r;
    oldest_nxt = oldest_r;
    cap_nxt    = cap_r;
    if (cfg_we) begin
      cap_nxt    = clamp_cap(cfg_value);
      fill_nxt   = '0;
      oldest_nxt = '0;
    end else if (do_insert) begin
      if (!full) begin
        fill_nxt = fill_r + CNT_W'(1);
      end else if (SUM_W'(oldest_r) + SUM_W'(1) >= SUM_W'(cap_r)) begin
        oldest_nxt = '0;
      end else begin
        oldest_nxt = oldest_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      oldest_r <= '0;
      cap_r    <= clamp_cap(CFG_RESET);
    end else begin
      fill_r   <= fill_nxt;
      oldest_r <= oldest_nxt;
      cap_r    <= cap_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_insert && !cfg_we) begin
      ent_pid_r[ins_slot]   <= req.process_id;
      ent_page_r[ins_slot]  <= req.page_number;
      ent_frame_r[ins_slot] <= req.frame_in;
    end
  end

endmodule

// File: src/tlb_lookup_fifo_replace_core.sv
// ----------------------------------------------------------------------------
// tlb_lookup_fifo_replace_core
// Fully associative translation buffer with first-in-first-out replacement.
//
// Input channel (in_*): one lookup or insert per transfer, taken when in_valid
// is high and in_stall is low. Result channel (out_*): one result per input
// item, in order, taken when out_valid is high and out_stall is low.
// The input register feeds a single pass of parallel tag compares against
// all entries and the insert update, which loads the result register when
// the input register advances. Throughput is one item per cycle while
// out_stall is low, with every entry compared in one pass.
// When out_stall holds a result, the input register holds too and in_stall
// rises once it is occupied; nothing is dropped.
// Configuration (cfg_*): a transfer on cfg_valid/cfg_ready writes
// entries_in_use and empties the table; cfg_ready is high while the input
// register is empty.
// Reset (rst_n low, synchronous) empties both stages and the table and sets
// entries_in_use to 16. Entry contents are not cleared.
// ----------------------------------------------------------------------------
module tlb_lookup_fifo_replace_core #(
  parameter int DEPTH = tlbf_pkg::TLB_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_op,
  input  logic [tlbf_pkg::PID_W-1:0]   in_process_id,
  input  logic [tlbf_pkg::PAGE_W-1:0]  in_page_number,
  input  logic [tlbf_pkg::FRAME_W-1:0] in_frame_in,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_hit,
  output logic [tlbf_pkg::FRAME_W-1:0] out_frame_out,
  output logic [tlbf_pkg::POS_W-1:0]   out_hit_position,
  output logic                         out_evicted,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [tlbf_pkg::CFG_W-1:0]   cfg_entries_in_use
);
  import tlbf_pkg::*;

  logic s1_valid_r, s1_valid_nxt;
  req_t s1_req_r;
  logic out_valid_r, out_valid_nxt;
  res_t out_res_r;
  res_t res;
  logic advance;
  logic in_take;
  logic cfg_we;

  assign advance   = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !advance;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = !s1_valid_r;
  assign cfg_we    = cfg_valid && cfg_ready;

  tlbf_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (s1_valid_r && advance),
    .req       (s1_req_r),
    .cfg_we    (cfg_we),
    .cfg_value (cfg_entries_in_use),
    .res       (res)
  );

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = s1_valid_r;
      s1_valid_nxt  = 1'b0;
    end
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_req_r <= '{op: op_t'(in_op), process_id: in_process_id,
                    page_number: in_page_number, frame_in: in_frame_in};
    end
    if (advance && s1_valid_r) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_res_r.hit;
  assign out_frame_out    = out_res_r.frame_out;
  assign out_hit_position = out_res_r.hit_position;
  assign out_evicted      = out_res_r.evicted;

endmodule

// File: src/tlbf_checker.sv
// ----------------------------------------------------------------------------
// tlbf_checker
// Port-level checks of the translation buffer, bound to the top level.
// ----------------------------------------------------------------------------
module tlbf_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         out_hit,
  input logic [tlbf_pkg::FRAME_W-1:0] out_frame_out,
  input logic [tlbf_pkg::POS_W-1:0]   out_hit_position,
  input logic                         out_evicted
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hit) &&
    $stable(out_frame_out) && $stable(out_hit_position) && $stable(out_evicted))
    else $error("stalled result changed");

  a_hit_or_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && out_evicted))
    else $error("hit and eviction on one result");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_frame_out == '0 && out_hit_position == '0)
    else $error("miss result carries frame or position");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with result side free");

endmodule

bind tlb_lookup_fifo_replace_core tlbf_checker u_tlbf_checker (.*);
